// ===== design/bitmap_frame_allocator_unit_macros.svh =====
// Assertion macros used by the checker in bfa_checker.sv.
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define BFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfa check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define BFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfa check failed");

`endif

// ===== design/bfa_pkg.sv =====
package bfa_pkg;

  localparam int NUM_FRAMES_DEF = 32;

  localparam int OP_W    = 2;
  localparam int COUNT_W = 6;
  localparam int INDEX_W = 5;
  localparam int GRANT_W = 5;
  localparam int FREE_W  = 6;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_ROOM = 1'b1;

  // Update request from the sequencer to the frame map.
  typedef struct packed {
    logic set;  // mark the addressed frame used
    logic clr;  // mark the addressed frame free
  } map_cmd_t;

endpackage

// ===== design/bfa_scan.sv =====
module bfa_scan #(
  parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
  localparam int IDX_W = $clog2(NUM_FRAMES)
) (
  input  logic [NUM_FRAMES-1:0] used_map,
  output logic [IDX_W-1:0]      lowest
);

  // Priority encoder: lowest-numbered free frame, zero when none is free.
  always_comb begin
    lowest = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (!used_map[i]) begin
        lowest = IDX_W'(i);
      end
    end
  end

endmodule

// ===== design/bfa_map.sv =====
module bfa_map #(
  parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
  localparam int IDX_W = $clog2(NUM_FRAMES),
  localparam int CNT_W = $clog2(NUM_FRAMES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bfa_pkg::map_cmd_t     cmd,
  input  logic [IDX_W-1:0]      frame,
  output logic [NUM_FRAMES-1:0] used_map,
  output logic [CNT_W-1:0]      free_cnt,
  output logic [CNT_W-1:0]      free_next
);

  logic [NUM_FRAMES-1:0] used_map_next;

  // The free count tracks the map so no popcount is ever needed.
  always_comb begin
    used_map_next = used_map;
    free_next     = free_cnt;
    if (cmd.set) begin
      used_map_next[frame] = 1'b1;
      free_next            = free_cnt - CNT_W'(1);
    end else if (cmd.clr && used_map[frame]) begin
      used_map_next[frame] = 1'b0;
      free_next            = free_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map <= '0;
      free_cnt <= CNT_W'(NUM_FRAMES);
    end else begin
      used_map <= used_map_next;
      free_cnt <= free_next;
    end
  end

endmodule

// ===== design/bitmap_frame_allocator_unit.sv =====
// A query, a release, a refused or an empty allocate gives its one result from DECIDE, after
// IDLE has captured the request. An allocate of n frames gives n results on consecutive cycles,
// one per GRANT state after DECIDE; busy covers DECIDE and every GRANT, otherwise DECIDE only.
// Throughput: one transaction at a time, set by the single priority encoder granting one frame
// per cycle. The receiver cannot stall, so a result strobe always lasts exactly one cycle.
// Reset (rst, synchronous, active high) marks every frame free and returns to idle.
module bitmap_frame_allocator_unit #(
  parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bfa_pkg::OP_W-1:0]    op,
  input  logic [bfa_pkg::COUNT_W-1:0] frame_count,
  input  logic [bfa_pkg::INDEX_W-1:0] frame_index,
  output logic                        busy,
  output logic                        strobe,
  output logic [bfa_pkg::GRANT_W-1:0] granted_frame,
  output logic                        status,
  output logic [bfa_pkg::FREE_W-1:0]  free_frames,
  output logic                        last
);

  localparam int IDX_W = $clog2(NUM_FRAMES);
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);

  // The sequencer walks every transaction through DECIDE. An allocate that fits then
  // stays in GRANT until every frame is granted, each grant reusing the same priority encoder.
  typedef enum logic [1:0] {
    IDLE,
    DECIDE,
    GRANT
  } state_t;

  state_t state;

  // Captured request. The remaining count never exceeds the request, so six bits suffice.
  logic [bfa_pkg::OP_W-1:0]    op_q;
  logic [bfa_pkg::COUNT_W-1:0] want_q;
  logic [bfa_pkg::INDEX_W-1:0] index_q;
  logic [bfa_pkg::COUNT_W-1:0] remain;

  bfa_pkg::map_cmd_t     cmd;
  logic [IDX_W-1:0]      map_frame;
  logic [NUM_FRAMES-1:0] used_map;
  logic [CNT_W-1:0]      free_cnt;
  logic [CNT_W-1:0]      free_next;
  logic [IDX_W-1:0]      lowest;

  // Wide views used for range checks and for truncating to the fixed port widths.
  logic [6:0] index_wide;
  logic [6:0] lowest_wide;
  logic [7:0] free_next_wide;
  logic       index_in_range;
  logic       short_of_frames;

  assign busy = (state != IDLE);

  assign index_wide      = 7'(index_q);
  assign lowest_wide     = 7'(lowest);
  assign free_next_wide  = 8'(free_next);
  assign index_in_range  = (index_wide < 7'(NUM_FRAMES));
  assign short_of_frames = (8'(free_cnt) < 8'(want_q));

  bfa_scan #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_scan (
    .used_map(used_map),
    .lowest  (lowest)
  );

  bfa_map #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .frame    (map_frame),
    .used_map (used_map),
    .free_cnt (free_cnt),
    .free_next(free_next)
  );

  // Map updates: a grant marks the encoder's frame used; a release in range frees its
  // frame. A release of a frame that is already free leaves the map as it was.
  always_comb begin
    cmd       = '0;
    map_frame = lowest;
    if (state == GRANT) begin
      cmd.set = 1'b1;
    end else if (state == DECIDE && op_q == bfa_pkg::OP_RELEASE) begin
      cmd.clr   = index_in_range;
      map_frame = index_wide[IDX_W-1:0];
    end
  end

  // Every result carries the free count as it stands after that result, which is exactly
  // the map's next count in the cycle the result is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            op_q    <= op;
            want_q  <= frame_count;
            index_q <= frame_index;
            state   <= DECIDE;
          end
        end
        DECIDE: begin
          granted_frame <= '0;
          free_frames   <= free_next_wide[bfa_pkg::FREE_W-1:0];
          status        <= bfa_pkg::STATUS_OK;
          last          <= 1'b1;
          if (op_q == bfa_pkg::OP_ALLOC && want_q != '0 && !short_of_frames) begin
            // Enough room: the grant burst produces every result.
            remain <= want_q;
            state  <= GRANT;
          end else begin
            // Release, query, the unused code, an empty allocate or a refusal.
            strobe <= 1'b1;
            if (op_q == bfa_pkg::OP_ALLOC && short_of_frames) begin
              status <= bfa_pkg::STATUS_NO_ROOM;
            end
            state <= IDLE;
          end
        end
        GRANT: begin
          strobe        <= 1'b1;
          granted_frame <= lowest_wide[bfa_pkg::GRANT_W-1:0];
          free_frames   <= free_next_wide[bfa_pkg::FREE_W-1:0];
          status        <= bfa_pkg::STATUS_OK;
          last          <= (remain == bfa_pkg::COUNT_W'(1));
          remain        <= remain - bfa_pkg::COUNT_W'(1);
          if (remain == bfa_pkg::COUNT_W'(1)) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/bfa_checker.sv =====
`include "bitmap_frame_allocator_unit_macros.svh"

module bfa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        strobe,
  input logic [bfa_pkg::GRANT_W-1:0] granted_frame,
  input logic                        status,
  input logic                        last
);

  // A refusal is a single result with no frame in it.
  `BFA_ASSERT_NOW(a_refusal_alone, strobe && status, last && granted_frame == '0)
  // Only a grant burst has results that are not last, and those are never refusals.
  `BFA_ASSERT_NOW(a_burst_ok, strobe && !last, status == bfa_pkg::STATUS_OK && busy)
  // A grant burst runs without gaps until its last result.
  `BFA_ASSERT_NEXT(a_burst_gapless, strobe && !last, strobe)
  // The final result of a transaction coincides with the block being free again.
  `BFA_ASSERT_NOW(a_last_idle, strobe && last, !busy)
  // An accepted transaction makes the block busy.
  `BFA_ASSERT_NEXT(a_start_busy, start && !busy, busy)

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .strobe       (strobe),
  .granted_frame(granted_frame),
  .status       (status),
  .last         (last)
);

// ===== bench/bitmap_frame_allocator_unit_checker.sv =====
`timescale 1ns / 1ps

module bitmap_frame_allocator_unit_checker #(
  parameter int NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [bfa_pkg::OP_W-1:0]    op,
  input  logic [bfa_pkg::COUNT_W-1:0] frame_count,
  input  logic [bfa_pkg::INDEX_W-1:0] frame_index,
  input  logic                        strobe,
  input  logic [bfa_pkg::GRANT_W-1:0] granted_frame,
  input  logic                        status,
  input  logic [bfa_pkg::FREE_W-1:0]  free_frames,
  input  logic                        last,
  input  logic                        check_leftovers,
  output int                          mismatch_count,
  output int                          pending,
  output int                          result_count
);

  typedef struct packed {
    logic [bfa_pkg::GRANT_W-1:0] frame;
    logic                        status;
    logic [bfa_pkg::FREE_W-1:0]  free;
    logic                        last;
  } frame_result_t;

  frame_result_t         expected_results[$];
  logic [NUM_FRAMES-1:0] frame_used = '0;
  logic                  leftovers_checked = 1'b0;

  initial begin
    mismatch_count = 0;
    pending        = 0;
    result_count   = 0;
  end

  function automatic int free_frame_count();
    int n;
    n = 0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (!frame_used[i]) n++;
    end
    return n;
  endfunction

  function automatic int lowest_free_frame();
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (!frame_used[i]) return i;
    end
    return 0;
  endfunction

  // The free count in each result is taken after the map update for that result.
  task automatic push_result(input int frame, input logic stat, input logic is_last);
    frame_result_t r;
    r.frame  = frame[bfa_pkg::GRANT_W-1:0];
    r.status = stat;
    r.free   = bfa_pkg::FREE_W'(free_frame_count());
    r.last   = is_last;
    expected_results.push_back(r);
  endtask

  task automatic predict_transaction(input logic [bfa_pkg::OP_W-1:0] cmd,
                                     input logic [bfa_pkg::COUNT_W-1:0] want,
                                     input logic [bfa_pkg::INDEX_W-1:0] idx);
    int f;
    case (cmd)
      bfa_pkg::OP_ALLOC: begin
        if (want == 0) begin
          push_result(0, bfa_pkg::STATUS_OK, 1'b1);
        end else if (free_frame_count() < int'(want)) begin
          push_result(0, bfa_pkg::STATUS_NO_ROOM, 1'b1);
        end else begin
          for (int k = 0; k < int'(want); k++) begin
            f = lowest_free_frame();
            frame_used[f] = 1'b1;
            push_result(f, bfa_pkg::STATUS_OK, k == int'(want) - 1);
          end
        end
      end
      bfa_pkg::OP_RELEASE: begin
        if (int'(idx) < NUM_FRAMES) frame_used[idx] = 1'b0;
        push_result(0, bfa_pkg::STATUS_OK, 1'b1);
      end
      default: begin
        push_result(0, bfa_pkg::STATUS_OK, 1'b1);
      end
    endcase
  endtask

  // Printing stops after a while so a badly broken block cannot flood the log.
  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40) begin
      $display("[%0t] ERROR %s: got %0d, expected %0d", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    frame_result_t r;
    if (rst) begin
      frame_used = '0;
      expected_results.delete();
    end else begin
      if (strobe) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no transaction outstanding", int'(granted_frame), 0);
        end else begin
          r = expected_results.pop_front();
          if (granted_frame !== r.frame)
            report_mismatch("granted_frame", int'(granted_frame), int'(r.frame));
          if (status !== r.status)
            report_mismatch("status", int'(status), int'(r.status));
          if (free_frames !== r.free)
            report_mismatch("free_frames", int'(free_frames), int'(r.free));
          if (last !== r.last) report_mismatch("last", int'(last), int'(r.last));
        end
      end
      if (start && !busy) predict_transaction(op, frame_count, frame_index);
      if (check_leftovers && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_results.size() != 0)
          report_mismatch("results never delivered", 0, expected_results.size());
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== bench/bitmap_frame_allocator_unit_tb.sv =====
`timescale 1ns / 1ps

module bitmap_frame_allocator_unit_tb;

  localparam int NUM_FRAMES     = bfa_pkg::NUM_FRAMES_DEF;
  localparam int RANDOM_ITEMS   = 340;
  localparam int WATCHDOG_LIMIT = 2000;

  // Op code three is unused by the block and is decoded as a query.
  localparam logic [bfa_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every input is at a known value from time zero.
  logic                        start       = 1'b0;
  logic [bfa_pkg::OP_W-1:0]    op          = bfa_pkg::OP_QUERY;
  logic [bfa_pkg::COUNT_W-1:0] frame_count = '0;
  logic [bfa_pkg::INDEX_W-1:0] frame_index = '0;

  logic                        busy;
  logic                        strobe;
  logic [bfa_pkg::GRANT_W-1:0] granted_frame;
  logic                        status;
  logic [bfa_pkg::FREE_W-1:0]  free_frames;
  logic                        last;

  logic check_leftovers = 1'b0;
  int   mismatch_count;
  int   pending;
  int   result_count;
  int   sent_count = 0;
  int   idle_cycles = 0;

  always #6 clk = ~clk;

  bitmap_frame_allocator_unit #(
    .NUM_FRAMES(NUM_FRAMES)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .op           (op),
    .frame_count  (frame_count),
    .frame_index  (frame_index),
    .busy         (busy),
    .strobe       (strobe),
    .granted_frame(granted_frame),
    .status       (status),
    .free_frames  (free_frames),
    .last         (last)
  );

  // The checker watches both channels on its own, keeps the predicted frame map and
  // compares every result; this module only makes stimulus and gives the verdict.
  bitmap_frame_allocator_unit_checker #(
    .NUM_FRAMES(NUM_FRAMES)
  ) checker_inst (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .frame_count    (frame_count),
    .frame_index    (frame_index),
    .strobe         (strobe),
    .granted_frame  (granted_frame),
    .status         (status),
    .free_frames    (free_frames),
    .last           (last),
    .check_leftovers(check_leftovers),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .result_count   (result_count)
  );

  // The watchdog counts cycles in which no transaction is accepted on either side. The
  // longest legal quiet stretch is a sender gap plus the block's latency, so the limit
  // leaves a wide margin.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("bitmap_frame_allocator_unit: mismatch");
        $finish;
      end
    end
  end

  // Start stays high after acceptance; the caller either presents the next transaction
  // in the same step or lowers start for a gap, so start gets one assignment per step.
  task automatic send_transaction(input logic [bfa_pkg::OP_W-1:0] cmd,
                                  input logic [bfa_pkg::COUNT_W-1:0] want,
                                  input logic [bfa_pkg::INDEX_W-1:0] idx);
    start       <= 1'b1;
    op          <= cmd;
    frame_count <= want;
    frame_index <= idx;
    do @(posedge clk); while (busy);
    sent_count++;
  endtask

  // During a gap the payload carries noise, which the block must ignore.
  task automatic idle_for(input int cycles);
    start       <= 1'b0;
    op          <= bfa_pkg::OP_W'($urandom);
    frame_count <= bfa_pkg::COUNT_W'($urandom);
    frame_index <= bfa_pkg::INDEX_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the sender off until every outstanding result has come back. It first waits for
  // the checker to register the transaction that was accepted last.
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly small allocates against frequent single-frame releases, so the map fills up
  // and then hovers near full, where refusals and exact fits happen often.
  task automatic send_random_transaction();
    int sel;
    int size_sel;
    logic [bfa_pkg::OP_W-1:0]    cmd;
    logic [bfa_pkg::COUNT_W-1:0] want;
    sel      = $urandom_range(0, 99);
    size_sel = $urandom_range(0, 99);
    want     = bfa_pkg::COUNT_W'($urandom);
    if (sel < 45) begin
      cmd = bfa_pkg::OP_ALLOC;
      if (size_sel < 75) want = bfa_pkg::COUNT_W'($urandom_range(1, 4));
      else if (size_sel < 90) want = bfa_pkg::COUNT_W'($urandom_range(5, 32));
      else if (size_sel < 95) want = bfa_pkg::COUNT_W'($urandom_range(33, 63));
      else want = '0;
    end else if (sel < 85) begin
      cmd = bfa_pkg::OP_RELEASE;
    end else if (sel < 95) begin
      cmd = bfa_pkg::OP_QUERY;
    end else begin
      cmd = OP_SPARE;
    end
    send_transaction(cmd, want, bfa_pkg::INDEX_W'($urandom));
  endtask

  initial begin
    int burst_left;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Query on an empty map, an empty allocate, then taking every frame
    // at once, which must succeed because exactly enough are free.
    send_transaction(bfa_pkg::OP_QUERY, 6'd0, 5'd0);
    send_transaction(bfa_pkg::OP_ALLOC, 6'd0, 5'd31);
    send_transaction(bfa_pkg::OP_ALLOC, 6'd32, 5'd0);
    // With the map full, a one-frame allocate is refused and the map stays full.
    send_transaction(bfa_pkg::OP_ALLOC, 6'd1, 5'd0);
    send_transaction(bfa_pkg::OP_QUERY, 6'd63, 5'd31);
    send_transaction(OP_SPARE, 6'd0, 5'd0);
    // Releases at both ends of the index range, one of them of a frame already free.
    send_transaction(bfa_pkg::OP_RELEASE, 6'd63, 5'd31);
    send_transaction(bfa_pkg::OP_RELEASE, 6'd0, 5'd31);
    send_transaction(bfa_pkg::OP_RELEASE, 6'd0, 5'd0);
    // Exactly enough again, with the two free frames at opposite ends of the map.
    send_transaction(bfa_pkg::OP_ALLOC, 6'd2, 5'd0);
    idle_for(3);
    send_transaction(bfa_pkg::OP_RELEASE, 6'd0, 5'd5);
    send_transaction(bfa_pkg::OP_RELEASE, 6'd0, 5'd17);
    send_transaction(bfa_pkg::OP_RELEASE, 6'd0, 5'd30);
    // Requests beyond the map size are always refused.
    send_transaction(bfa_pkg::OP_ALLOC, 6'd63, 5'd0);
    send_transaction(bfa_pkg::OP_ALLOC, 6'd33, 5'd0);
    // Four asked with three free is refused, then three fit exactly.
    send_transaction(bfa_pkg::OP_ALLOC, 6'd4, 5'd0);
    send_transaction(bfa_pkg::OP_ALLOC, 6'd3, 5'd21);
    send_transaction(bfa_pkg::OP_RELEASE, 6'd0, 5'd10);
    send_transaction(bfa_pkg::OP_RELEASE, 6'd0, 5'd11);
    send_transaction(bfa_pkg::OP_ALLOC, 6'd1, 5'd0);
    send_transaction(OP_SPARE, 6'd42, 5'd21);
    wait_for_results();

    // Random part: bursts of random length with random gaps, some bursts long enough
    // to give stretches with no idling, and one full drain in the middle.
    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (burst_left == 0) begin
        idle_for($urandom_range(1, 10));
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 8);
      end
      send_random_transaction();
      burst_left--;
      if (i == RANDOM_ITEMS / 2) begin
        wait_for_results();
        burst_left = 0;
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    check_leftovers <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Run covered %0d transactions and %0d results: corner cases first, then",
             sent_count, result_count);
    $display("random allocates, releases and queries with the map often full.");
    if (mismatch_count == 0) begin
      $display("bitmap_frame_allocator_unit: match");
    end else begin
      $display("bitmap_frame_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/bfa_pkg.sv
design/bfa_scan.sv
design/bfa_map.sv
design/bitmap_frame_allocator_unit.sv
design/bfa_checker.sv
bench/bitmap_frame_allocator_unit_checker.sv
bench/bitmap_frame_allocator_unit_tb.sv
